// ----- src/trial_division_prime_test_top_defines.svh -----
// Assertion macros shared by the trial-division prime tester.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TDPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tdpt_pkg.sv -----
// Types shared by the controller and datapath of the trial-division prime tester.
package tdpt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL
    } tdpt_state_t;

    typedef struct packed {
        logic load;       // capture the input value
        logic first_div;  // set the trial divisor to two
        logic next_div;   // advance the trial divisor by one
        logic div_init;   // restart the divider on the stored value
        logic div_step;   // one restoring division step
        logic finish;     // register the answer and raise the strobe
        logic prime;      // answer given with finish
    } tdpt_cmd_t;

    typedef struct packed {
        logic neg;        // sign bit of the stored value
        logic le_one;     // stored value is zero or one
        logic div_last;   // final division step is in progress
        logic quo_lt_div; // quotient below the divisor: no divisor left to try
        logic rem_zero;   // remainder is zero
    } tdpt_status_t;

endpackage

// ----- src/tdpt_dp.sv -----
// Datapath: value store, trial divisor and a one-bit-per-cycle restoring divider.
module tdpt_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [DATA_WIDTH-1:0]    value,
    input  tdpt_pkg::tdpt_cmd_t      cmd,
    output tdpt_pkg::tdpt_status_t   status,
    output logic                     done,
    output logic                     is_prime
);
    import tdpt_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] div_reg, div_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  prime_reg, prime_next;
    logic [DATA_WIDTH-1:0] trial;

    // The remainder stays below the divisor, so the shifted partial remainder fits.
    assign trial = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};

    always_comb
    begin
        val_next   = val_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = cmd.finish;
        prime_next = prime_reg;
        if (cmd.load)
        begin
            val_next = value;
        end
        if (cmd.first_div)
        begin
            div_next = DATA_WIDTH'(2);
        end
        else if (cmd.next_div)
        begin
            div_next = div_reg + DATA_WIDTH'(1);
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            quo_next = val_reg;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= div_reg)
            begin
                rem_next = trial - div_reg;
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            prime_next = cmd.prime;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
    end

    assign status.neg        = val_reg[DATA_WIDTH-1];
    assign status.le_one     = (val_reg[DATA_WIDTH-1:1] == '0);
    assign status.div_last   = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign status.quo_lt_div = (quo_reg < div_reg);
    assign status.rem_zero   = (rem_reg == '0);

    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

// ----- src/tdpt_ctrl.sv -----
// Controller state machine sequencing the trial divisions.
module tdpt_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  tdpt_pkg::tdpt_status_t  status,
    output tdpt_pkg::tdpt_cmd_t     cmd,
    output logic                    busy
);
    import tdpt_pkg::*;

    tdpt_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.neg || status.le_one)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.quo_lt_div || status.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CHECK:
            begin
                if (status.neg || status.le_one)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.first_div = 1'b1;
                    cmd.div_init  = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EVAL:
            begin
                // A quotient below the divisor means the divisor passed the square root.
                if (status.quo_lt_div)
                begin
                    cmd.finish = 1'b1;
                    cmd.prime  = 1'b1;
                end
                else if (status.rem_zero)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    cmd.div_init = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/trial_division_prime_test_top.sv -----
// Values of one or less go from the check state straight to the done beat.
// Otherwise k trial divisors are tried, k being at most about the square root of the value.
// Each divisor costs one restoring divider pass of DATA_WIDTH steps plus one check.
// One value is in flight at a time; the next start is taken in the done cycle.
// Reset clears the controller and the done strobe; the block is then idle.
`include "trial_division_prime_test_top_defines.svh"

module trial_division_prime_test_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  busy,
    output logic                  done,
    output logic                  is_prime
);
    import tdpt_pkg::*;

    tdpt_cmd_t    cmd;
    tdpt_status_t status;
    logic         accept_neg;

    tdpt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tdpt_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .is_prime (is_prime)
    );

    assign accept_neg = start && !busy && value[DATA_WIDTH-1];

    `TDPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after an accepted beat")
    `TDPT_ASSERT_SAME(a_done_idle, done, !busy, "done beat while still busy")
    `TDPT_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
    `TDPT_ASSERT_NEXT(a_neg_fast, accept_neg, ##1 (done && !is_prime), "negative not rejected")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the trial-division prime tester.
module tb_top;

    localparam int W              = 32;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 88;
    localparam int REPORT_CAP     = 10;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic [W-1:0] value;
    logic         busy;
    logic         done;
    logic         is_prime;

    int unsigned  quiet_cycles;

    trial_division_prime_test_top #(
        .DATA_WIDTH(W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .value   (value),
        .busy    (busy),
        .done    (done),
        .is_prime(is_prime)
    );

    always #2 clk = ~clk;

    class prime_scoreboard;
        typedef struct {
            logic [W-1:0] operand;
            bit           prime;
        } verdict_t;

        verdict_t    verdict_q[$];
        int unsigned failures;
        int unsigned results_seen;
        int unsigned items_seen;
        int unsigned primes_seen;
        int unsigned negatives_seen;

        // Divisors are tried only while d * d stays within the operand.
        function bit primality_of(logic [W-1:0] v);
            longint unsigned n;
            longint unsigned d;
            if (v[W-1])
                return 1'b0;
            n = v;
            if (n <= 1)
                return 1'b0;
            for (d = 2; d <= n / d; d++)
            begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(logic [W-1:0] v);
            verdict_t entry;
            entry.operand = v;
            entry.prime   = primality_of(v);
            verdict_q.push_back(entry);
            items_seen++;
            if (entry.prime)
                primes_seen++;
            if (v[W-1])
                negatives_seen++;
        endfunction

        function void check_result(logic got);
            verdict_t entry;
            if (verdict_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("ERROR: result beat with nothing outstanding, is_prime=%b", got);
                return;
            end
            entry = verdict_q.pop_front();
            results_seen++;
            if (got !== entry.prime)
            begin
                failures++;
                if (failures <= REPORT_CAP)
                    $display("ERROR: value %0d (0x%08h): is_prime expected %b, got %b",
                             $signed(entry.operand), entry.operand, entry.prime, got);
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    prime_scoreboard sb = new;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(is_prime);
    end

    // Counts cycles in which no beat moves in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("trial_division_prime_test_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_value(input logic [W-1:0] v, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_value(v);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Large positive values always carry a small factor, so a long prime search never occurs.
    function automatic logic [W-1:0] random_value();
        int unsigned pick;
        int unsigned factor;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return $urandom_range(0, 1023);
        if (pick < 70)
            return $urandom_range(1024, 65535);
        if (pick < 85)
            return $urandom() | 32'h8000_0000;
        factor = $urandom_range(2, 13);
        return $urandom_range(1, 32'h7FFF_FFFF / factor) * factor;
    endfunction

    task automatic run_random(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send_value(random_value(), idle_pct);
    endtask

    initial
    begin
        logic [W-1:0] directed[$];
        directed = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
            32'd961, 32'd997, 32'd1024, 32'd65521, 32'd65535, 32'd1000003,
            32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h8000_0002,
            32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFB, 32'h4000_0000,
            32'h5555_5555, 32'h2AAA_AAAA
        };
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i], 30);
        run_random(PHASE_ITEMS, 30);
        // The sender waits here for every outstanding beat before changing pace.
        hold_until_drained();
        run_random(PHASE_ITEMS, 67);
        hold_until_drained();
        run_random(PHASE_ITEMS, 0);
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Tested %0d values (%0d prime, %0d negative); %0d result beats compared.",
                 sb.items_seen, sb.primes_seen, sb.negatives_seen, sb.results_seen);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("trial_division_prime_test_top verification clean");
        else
        begin
            $display("%0d failures, %0d results never arrived.", sb.failures, sb.pending());
            $display("trial_division_prime_test_top verification failed");
        end
        $finish;
    end

endmodule
